// ===== hdl/crc_fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-framed packet receiver package
// Shared constants, the start descriptor type and the byte-wide CRC-16 step.
// ----------------------------------------------------------------------------
`default_nettype none

package crc_fpr_pkg;

   // Default payload store depth in bytes.
   localparam int PAYLOAD_DEPTH_DEF = 64;

   // Field widths of the result beat.
   localparam int ID_W    = 16;
   localparam int LEN_W   = 7;
   localparam int IDX_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int CRC_W   = 16;

   // Framing bytes and CRC constants.
   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
   localparam logic [BYTE_W-1:0] FOOTER_MARK = 8'hEE;
   localparam logic [CRC_W-1:0]  CRC_POLY    = 16'hA001;
   localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;

   // Request from the parser to the emitter when a good frame closes.
   typedef struct packed {
      logic              start;
      logic [ID_W-1:0]   pkt_id;
      logic [BYTE_W-1:0] length;
   } emit_req_type;

   // One byte of the reflected CRC-16, LSB first.
   function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/crc_fpr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_fpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/crc_fpr_emitter.sv =====
// ----------------------------------------------------------------------------
// Frame emitter
// Reads the stored payload back and drives the result beats through an
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_fpr_emitter #(
   parameter int PAYLOAD_DEPTH = crc_fpr_pkg::PAYLOAD_DEPTH_DEF,
   localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire crc_fpr_pkg::emit_req_type     emit_req,
   output logic                               busy,
   output logic                               ram_rd_en,
   output logic [AW-1:0]                      ram_rd_addr,
   input  wire logic [crc_fpr_pkg::BYTE_W-1:0] ram_rd_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [crc_fpr_pkg::ID_W-1:0]       rsp_frame_id,
   output logic [crc_fpr_pkg::LEN_W-1:0]      rsp_frame_length,
   output logic                               rsp_has_payload,
   output logic [crc_fpr_pkg::IDX_W-1:0]      rsp_byte_index,
   output logic [crc_fpr_pkg::BYTE_W-1:0]     rsp_payload_byte,
   output logic                               rsp_last
);

   import crc_fpr_pkg::*;

   typedef enum logic [2:0] {
      EM_IDLE = 3'b001,
      EM_READ = 3'b010,
      EM_LOAD = 3'b100
   } em_state_type;

   em_state_type      state_ff, state_in;
   logic [BYTE_W-1:0] idx_ff, idx_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [BYTE_W-1:0] len_ff, len_in;

   logic              out_valid_ff, out_valid_in;
   logic [ID_W-1:0]   out_id_ff, out_id_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic              out_hasp_ff, out_hasp_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic              load_en;
   logic              is_last;
   logic              is_empty;
   logic [BYTE_W-1:0] idx_next;

   assign idx_next = idx_ff + 8'd1;
   assign is_empty = (len_ff == '0);
   assign is_last  = is_empty || (idx_next == len_ff);
   assign load_en  = (state_ff == EM_LOAD) && (!out_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      id_in        = id_ff;
      len_in       = len_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_id_in    = out_id_ff;
      out_len_in   = out_len_ff;
      out_hasp_in  = out_hasp_ff;
      out_idx_in   = out_idx_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff[AW-1:0];

      case (state_ff)
         EM_IDLE: begin
            if (emit_req.start) begin
               id_in    = emit_req.pkt_id;
               len_in   = emit_req.length;
               idx_in   = '0;
               state_in = EM_READ;
            end
         end
         EM_READ: begin
            ram_rd_en = 1'b1;
            state_in  = EM_LOAD;
         end
         EM_LOAD: begin
            if (load_en) begin
               out_valid_in = 1'b1;
               out_id_in    = id_ff;
               out_len_in   = len_ff[LEN_W-1:0];
               out_hasp_in  = !is_empty;
               out_idx_in   = idx_ff[IDX_W-1:0];
               out_byte_in  = is_empty ? '0 : ram_rd_data;
               out_last_in  = is_last;
               if (is_last) begin
                  state_in = EM_IDLE;
               end else begin
                  idx_in   = idx_next;
                  state_in = EM_READ;
               end
            end
         end
         default: begin
            state_in = EM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EM_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff      <= idx_in;
      id_ff       <= id_in;
      len_ff      <= len_in;
      out_id_ff   <= out_id_in;
      out_len_ff  <= out_len_in;
      out_hasp_ff <= out_hasp_in;
      out_idx_ff  <= out_idx_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign busy             = (state_ff != EM_IDLE);
   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_id     = out_id_ff;
   assign rsp_frame_length = out_len_ff;
   assign rsp_has_payload  = out_hasp_ff;
   assign rsp_byte_index   = out_idx_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_last         = out_last_ff;

   // A new frame may only be handed over while the previous run is done.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      emit_req.start |-> (state_ff == EM_IDLE))
      else $error("emit request while emitter busy");

   // The load step always follows a RAM read or a stalled load.
   a_load_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EM_LOAD) |-> ($past(state_ff) == EM_READ || $past(state_ff) == EM_LOAD))
      else $error("load without preceding read");

   // Reads stay inside the frame's payload.
   a_read_in_frame: assert property (@(posedge clock) disable iff (reset)
      (ram_rd_en && !is_empty) |-> (idx_ff < len_ff))
      else $error("payload read past frame length");

endmodule

`default_nettype wire

// ===== hdl/crc_framed_packet_receiver_core.sv =====
// ----------------------------------------------------------------------------
// CRC-framed packet receiver core
// Parses sync, id, length, payload, CRC and footer from a byte stream and
// emits each good frame as a run of payload beats.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   req_*     in         data_byte: one received byte of the stream
//   rsp_*     out        frame_id, frame_length, has_payload, byte_index,
//                        payload_byte, last
//
// Each accepted sync, id, length and payload byte is folded into the CRC-16.
// After a good footer, input is held off while the emitter replays the RAM:
// each payload beat takes a RAM read, then an output load that waits on a
// stalled output; an empty frame gives its single beat the same way.
// Once the final beat is loaded, new bytes are taken even while it stalls.
// Reset clears the control state; every RAM entry whose data is emitted is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_packet_receiver_core #(
   parameter int PAYLOAD_DEPTH = crc_fpr_pkg::PAYLOAD_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [crc_fpr_pkg::BYTE_W-1:0] req_data_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [crc_fpr_pkg::ID_W-1:0]        rsp_frame_id,
   output logic [crc_fpr_pkg::LEN_W-1:0]       rsp_frame_length,
   output logic                                rsp_has_payload,
   output logic [crc_fpr_pkg::IDX_W-1:0]       rsp_byte_index,
   output logic [crc_fpr_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic                                rsp_last
);

   import crc_fpr_pkg::*;

   localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam logic [BYTE_W-1:0] DEPTH_B = BYTE_W'(PAYLOAD_DEPTH);

   // Parser phases, one-hot.
   typedef enum logic [8:0] {
      PH_SYNC1   = 9'b000000001,
      PH_SYNC2   = 9'b000000010,
      PH_ID_LO   = 9'b000000100,
      PH_ID_HI   = 9'b000001000,
      PH_LEN     = 9'b000010000,
      PH_PAYLOAD = 9'b000100000,
      PH_CHK_LO  = 9'b001000000,
      PH_CHK_HI  = 9'b010000000,
      PH_FOOTER  = 9'b100000000
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [ID_W-1:0]   pkt_id_ff, pkt_id_in;
   logic [BYTE_W-1:0] length_ff, length_in;
   logic [BYTE_W-1:0] wr_idx_ff, wr_idx_in;
   logic [CRC_W-1:0]  rx_check_ff, rx_check_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;

   logic              accept;
   logic              emit_busy;
   logic [CRC_W-1:0]  crc_step;
   logic [BYTE_W-1:0] wr_idx_next;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;
   emit_req_type      emit_req;

   // Input is blocked only while the emitter is replaying a frame.
   assign req_ready   = !emit_busy;
   assign accept      = req_valid && req_ready;
   assign crc_step    = crc16_byte(crc_ff, req_data_byte);
   assign wr_idx_next = wr_idx_ff + 8'd1;
   assign ram_wr_en   = accept && (phase_ff == PH_PAYLOAD);

   always_comb begin
      phase_in          = phase_ff;
      pkt_id_in         = pkt_id_ff;
      length_in         = length_ff;
      wr_idx_in         = wr_idx_ff;
      rx_check_in       = rx_check_ff;
      crc_in            = crc_ff;
      emit_req.start    = 1'b0;
      emit_req.pkt_id   = pkt_id_ff;
      emit_req.length   = length_ff;

      if (accept) begin
         case (phase_ff)
            PH_SYNC2: begin
               // A wrong second byte is never reused as a first sync byte.
               if (req_data_byte == SYNC_SECOND) begin
                  crc_in   = crc_step;
                  phase_in = PH_ID_LO;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_ID_LO: begin
               pkt_id_in = {8'h00, req_data_byte};
               crc_in    = crc_step;
               phase_in  = PH_ID_HI;
            end
            PH_ID_HI: begin
               pkt_id_in = {req_data_byte, pkt_id_ff[7:0]};
               crc_in    = crc_step;
               phase_in  = PH_LEN;
            end
            PH_LEN: begin
               length_in = req_data_byte;
               wr_idx_in = '0;
               crc_in    = crc_step;
               if (req_data_byte > DEPTH_B) begin
                  phase_in = PH_SYNC1;
               end else if (req_data_byte == '0) begin
                  phase_in = PH_CHK_LO;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               wr_idx_in = wr_idx_next;
               crc_in    = crc_step;
               if (wr_idx_next >= length_ff) begin
                  phase_in = PH_CHK_LO;
               end
            end
            PH_CHK_LO: begin
               rx_check_in = {8'h00, req_data_byte};
               phase_in    = PH_CHK_HI;
            end
            PH_CHK_HI: begin
               rx_check_in = {req_data_byte, rx_check_ff[7:0]};
               phase_in    = PH_FOOTER;
            end
            PH_FOOTER: begin
               emit_req.start = (req_data_byte == FOOTER_MARK) && (crc_ff == rx_check_ff);
               phase_in       = PH_SYNC1;
            end
            default: begin
               // Hunting the first sync byte; the CRC restarts here.
               if (req_data_byte == SYNC_FIRST) begin
                  crc_in   = crc16_byte(CRC_INIT, req_data_byte);
                  phase_in = PH_SYNC2;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SYNC1;
         pkt_id_ff   <= '0;
         length_ff   <= '0;
         wr_idx_ff   <= '0;
         rx_check_ff <= '0;
         crc_ff      <= CRC_INIT;
      end else begin
         phase_ff    <= phase_in;
         pkt_id_ff   <= pkt_id_in;
         length_ff   <= length_in;
         wr_idx_ff   <= wr_idx_in;
         rx_check_ff <= rx_check_in;
         crc_ff      <= crc_in;
      end
   end

   crc_fpr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PAYLOAD_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_ff[AW-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   crc_fpr_emitter #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_emitter (
      .clock            (clock),
      .reset            (reset),
      .emit_req         (emit_req),
      .busy             (emit_busy),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_id     (rsp_frame_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_has_payload  (rsp_has_payload),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last)
   );

   // The payload RAM is never written while the emitter reads it back.
   a_no_write_during_emit: assert property (@(posedge clock) disable iff (reset)
      emit_busy |-> !ram_wr_en)
      else $error("payload write during emission");

   // Payload writes stay inside the declared frame length.
   a_write_in_frame: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (wr_idx_ff < length_ff) && (length_ff <= DEPTH_B))
      else $error("payload write outside frame");

   // The parser is always in exactly one phase.
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("parser phase not one-hot");

endmodule

`default_nettype wire

// ===== verif/crc_framed_packet_receiver_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-framed packet receiver core testbench
// Streams framed byte traffic (good frames, bad checks, bad footers, oversize
// lengths, broken sync and line noise) into the core with random gaps on both
// channels, and compares every payload beat against an internal parser model.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_packet_receiver_core_tb;

   import crc_fpr_pkg::*;

   // Parser phases of the local frame model.
   typedef enum logic [3:0] {
      HUNT_FIRST, HUNT_SECOND, GET_ID_LOW, GET_ID_HIGH, GET_LENGTH,
      GET_PAYLOAD, GET_CHECK_LOW, GET_CHECK_HIGH, GET_FOOTER
   } rx_phase_type;

   // Ways a generated frame can be damaged on the line.
   typedef enum int {INTACT, BAD_CHECK, BAD_FOOTER, OVERSIZE} frame_flaw_type;

   // One expected result beat, at the port widths.
   typedef struct {
      logic [ID_W-1:0]   pkt_id;
      logic [LEN_W-1:0]  frame_length;
      logic              has_payload;
      logic [IDX_W-1:0]  byte_index;
      logic [BYTE_W-1:0] payload_byte;
      logic              last;
   } frame_beat_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [BYTE_W-1:0] req_data_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [ID_W-1:0]   rsp_frame_id;
   logic [LEN_W-1:0]  rsp_frame_length;
   logic              rsp_has_payload;
   logic [IDX_W-1:0]  rsp_byte_index;
   logic [BYTE_W-1:0] rsp_payload_byte;
   logic              rsp_last;

   // Model state: mirrors what the receiver holds between bytes.
   rx_phase_type      rx_phase;
   logic [ID_W-1:0]   rx_pkt_id;
   logic [BYTE_W-1:0] rx_length;
   logic [BYTE_W-1:0] rx_bytes [PAYLOAD_DEPTH_DEF];
   int                rx_fill;
   logic [CRC_W-1:0]  rx_check_seen;
   logic [CRC_W-1:0]  rx_check_run;

   frame_beat_type    pending_beats [$];
   int                mismatch_count;
   int                bytes_accepted;
   bit                gapless;

   crc_framed_packet_receiver_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_id     (rsp_frame_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_has_payload  (rsp_has_payload),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Reflected CRC-16, one data bit at a time, LSB first.
   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      logic             feedback;
      c = crc;
      for (int k = 0; k < BYTE_W; k++) begin
         feedback = c[0] ^ data[k];
         c = c >> 1;
         if (feedback) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic int draw_gap();
      return gapless ? 0 : $urandom_range(0, 12);
   endfunction

   // Advance the frame model by one accepted byte and queue any beats that
   // a good footer releases.
   task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
      frame_beat_type beat;
      case (rx_phase)
         HUNT_SECOND: begin
            if (b == SYNC_SECOND) begin
               rx_check_run = crc_fold(rx_check_run, b);
               rx_phase = GET_ID_LOW;
            end else begin
               // The wrong byte is dropped, even when it is another 0xAA.
               rx_phase = HUNT_FIRST;
            end
         end
         GET_ID_LOW: begin
            rx_pkt_id = {8'h00, b};
            rx_check_run = crc_fold(rx_check_run, b);
            rx_phase = GET_ID_HIGH;
         end
         GET_ID_HIGH: begin
            rx_pkt_id[15:8] = b;
            rx_check_run = crc_fold(rx_check_run, b);
            rx_phase = GET_LENGTH;
         end
         GET_LENGTH: begin
            rx_length = b;
            rx_fill = 0;
            rx_check_run = crc_fold(rx_check_run, b);
            if (b > PAYLOAD_DEPTH_DEF) begin
               rx_phase = HUNT_FIRST;
            end else if (b == 0) begin
               rx_phase = GET_CHECK_LOW;
            end else begin
               rx_phase = GET_PAYLOAD;
            end
         end
         GET_PAYLOAD: begin
            if (rx_fill < PAYLOAD_DEPTH_DEF) begin
               rx_bytes[rx_fill] = b;
            end
            rx_fill++;
            rx_check_run = crc_fold(rx_check_run, b);
            if (rx_fill >= rx_length) begin
               rx_phase = GET_CHECK_LOW;
            end
         end
         GET_CHECK_LOW: begin
            rx_check_seen = {8'h00, b};
            rx_phase = GET_CHECK_HIGH;
         end
         GET_CHECK_HIGH: begin
            rx_check_seen[15:8] = b;
            rx_phase = GET_FOOTER;
         end
         GET_FOOTER: begin
            if (b == FOOTER_MARK && rx_check_run == rx_check_seen) begin
               beat.pkt_id       = rx_pkt_id;
               beat.frame_length = rx_length[LEN_W-1:0];
               if (rx_length == 0) begin
                  beat.has_payload  = 1'b0;
                  beat.byte_index   = '0;
                  beat.payload_byte = '0;
                  beat.last         = 1'b1;
                  pending_beats.push_back(beat);
               end else begin
                  for (int i = 0; i < rx_length; i++) begin
                     beat.has_payload  = 1'b1;
                     beat.byte_index   = i[IDX_W-1:0];
                     beat.payload_byte = rx_bytes[i];
                     beat.last         = (i == rx_length - 1);
                     pending_beats.push_back(beat);
                  end
               end
            end
            rx_phase = HUNT_FIRST;
         end
         default: begin
            if (b == SYNC_FIRST) begin
               rx_check_run = crc_fold(CRC_INIT, b);
               rx_phase = HUNT_SECOND;
            end else begin
               rx_phase = HUNT_FIRST;
            end
         end
      endcase
   endtask

   // Offer one byte after a random gap and hold it until it is taken.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do begin
         @(posedge clock);
      end while (!(req_valid && req_ready));
      parse_rx_byte(b);
      bytes_accepted++;
   endtask

   // Build a frame with random payload, damage it as asked, and send it.
   task automatic send_frame(input logic [ID_W-1:0] id, input int len,
                             input frame_flaw_type flaw);
      logic [BYTE_W-1:0] frame_bytes [$];
      logic [CRC_W-1:0]  crc;
      logic [BYTE_W-1:0] footer;
      frame_bytes = {SYNC_FIRST, SYNC_SECOND, id[7:0], id[15:8], 8'(len)};
      if (flaw != OVERSIZE) begin
         for (int i = 0; i < len; i++) begin
            frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
         crc = CRC_INIT;
         foreach (frame_bytes[i]) begin
            crc = crc_fold(crc, frame_bytes[i]);
         end
         if (flaw == BAD_CHECK) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
         end
         footer = FOOTER_MARK;
         if (flaw == BAD_FOOTER) begin
            do begin
               footer = 8'($urandom_range(0, 255));
            end while (footer == FOOTER_MARK);
         end
         frame_bytes.push_back(crc[7:0]);
         frame_bytes.push_back(crc[15:8]);
         frame_bytes.push_back(footer);
      end
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i]);
      end
   endtask

   // The last byte offered is already taken, so valid drops before waiting.
   task automatic wait_for_drain();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_beats.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                  input logic [31:0] want_v);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns",
               what, got_v, want_v, $time);
      mismatch_count++;
   endtask

   // Result checker: every accepted beat is compared with the oldest one
   // that the frame model has released.
   task automatic check_beat();
      frame_beat_type want;
      if (pending_beats.size() == 0) begin
         report_mismatch("unexpected beat, id", 32'(rsp_frame_id), 32'h0);
      end else begin
         want = pending_beats.pop_front();
         if (rsp_frame_id !== want.pkt_id)
            report_mismatch("id", 32'(rsp_frame_id), 32'(want.pkt_id));
         if (rsp_frame_length !== want.frame_length)
            report_mismatch("frame_length", 32'(rsp_frame_length),
                            32'(want.frame_length));
         if (rsp_has_payload !== want.has_payload)
            report_mismatch("has_payload", 32'(rsp_has_payload),
                            32'(want.has_payload));
         if (rsp_byte_index !== want.byte_index)
            report_mismatch("byte_index", 32'(rsp_byte_index), 32'(want.byte_index));
         if (rsp_payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 32'(rsp_payload_byte),
                            32'(want.payload_byte));
         if (rsp_last !== want.last)
            report_mismatch("last", 32'(rsp_last), 32'(want.last));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_beat();
      end
   end

   // Result-side back-pressure: a random stall before each beat.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            @(negedge clock) rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_ready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!(rsp_valid && rsp_ready));
      end
   end

   // ---- Tests --------------------------------------------------------------

   task automatic test_empty_frame();
      send_frame(16'hFFFF, 0, INTACT);
   endtask

   // A repeated 0xAA in the second sync slot must not restart the hunt, so
   // the following 0x55 is dropped as well; the next frame must still land.
   task automatic test_sync_recovery();
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_frame(16'h0000, 1, INTACT);
   endtask

   task automatic test_length_limit();
      send_frame(16'h1234, PAYLOAD_DEPTH_DEF + 1, OVERSIZE);
   endtask

   task automatic test_bad_footer();
      send_frame(16'h5A5A, 0, BAD_FOOTER);
   endtask

   task automatic test_bad_check();
      send_frame(16'hA5A5, 0, BAD_CHECK);
   endtask

   task automatic test_full_payload();
      send_frame(16'h8001, PAYLOAD_DEPTH_DEF, INTACT);
   endtask

   // Mostly well-formed frames of random content and small lengths, mixed
   // with damaged frames, broken sync and stray bytes.
   task automatic test_random_traffic();
      int start_count;
      int pick;
      int len;
      bit paused;
      start_count = bytes_accepted;
      paused = 1'b0;
      while (bytes_accepted - start_count < 40) begin
         gapless = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, PAYLOAD_DEPTH_DEF)
                                            : $urandom_range(0, 8);
         if (pick < 60) begin
            send_frame(16'($urandom_range(0, 65535)), len, INTACT);
         end else if (pick < 70) begin
            send_frame(16'($urandom_range(0, 65535)), len, BAD_CHECK);
         end else if (pick < 78) begin
            send_frame(16'($urandom_range(0, 65535)), len, BAD_FOOTER);
         end else if (pick < 84) begin
            send_frame(16'($urandom_range(0, 65535)),
                       $urandom_range(PAYLOAD_DEPTH_DEF + 1, 255), OVERSIZE);
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_byte(SYNC_FIRST);
            send_byte($urandom_range(0, 1) ? SYNC_FIRST : 8'($urandom_range(0, 84)));
         end
         // Once, midway, hold the sender until every released beat is out.
         if (!paused && bytes_accepted - start_count >= 20) begin
            paused = 1'b1;
            wait_for_drain();
         end
      end
      gapless = 1'b0;
   endtask

   // ---- Sequencer ----------------------------------------------------------

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      gapless        = 1'b0;
      mismatch_count = 0;
      bytes_accepted = 0;
      rx_phase       = HUNT_FIRST;
      rx_pkt_id      = '0;
      rx_length      = '0;
      rx_fill        = 0;
      rx_check_seen  = '0;
      rx_check_run   = CRC_INIT;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_empty_frame();
      test_sync_recovery();
      test_length_limit();
      test_bad_footer();
      test_bad_check();
      test_full_payload();
      test_random_traffic();

      wait_for_drain();
      // Allow a frame still in replay to show any stray beats.
      repeat (200) @(posedge clock);
      if (pending_beats.size() != 0) begin
         report_mismatch("beats never delivered", 32'h0, 32'(pending_beats.size()));
      end
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
